// File: design/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg: shared types and constants for the indexed list store
// Sizes, request and status codes, the cell command struct and word helpers.
// ----------------------------------------------------------------------------
package ils_pkg;

   localparam int DEPTH      = 16;
   localparam int WORD_WIDTH = 32;

   // fixed field widths of the request and response ports
   localparam int ACTION_W = 3;
   localparam int REQ_IDX_W = 5;
   localparam int DATA_W   = 32;
   localparam int LEN_W    = 5;
   localparam int STATUS_W = 2;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > REQ_IDX_W) ? CNT_W : REQ_IDX_W;

   localparam logic [ACTION_W-1:0] ACT_PUSH      = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_POP       = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_INSERT    = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_REMOVE    = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_READ      = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_OVERWRITE = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_RESIZE    = 3'd6;

   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_LOAD_AT,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_FILL
   } cell_op_type;

   typedef struct packed {
      cell_op_type       op;
      logic [CNT_W-1:0]  pos;
      logic [CNT_W-1:0]  lim;
   } cell_cmd_type;

   typedef struct packed {
      logic                rd_en;
      logic [IDX_W-1:0]    rd_sel;
      logic [STATUS_W-1:0] status;
      logic [CNT_W-1:0]    next_count;
   } ctrl_res_type;

   function automatic logic [WORD_WIDTH-1:0] data_to_word(logic [DATA_W-1:0] d);
      logic [63:0] t;
      t = 64'(d);
      return t[WORD_WIDTH-1:0];
   endfunction

   function automatic logic [DATA_W-1:0] word_to_data(logic [WORD_WIDTH-1:0] w);
      logic [63:0] t;
      t = 64'(w);
      return t[DATA_W-1:0];
   endfunction

endpackage

// File: design/ils_cell.sv
// ----------------------------------------------------------------------------
// ils_cell: one list entry
// Holds one word and each cycle keeps it, loads the request word, or takes
// the word of its lower or upper neighbor.
// ----------------------------------------------------------------------------
module ils_cell (
   input  logic                          clock,
   input  logic [ils_pkg::IDX_W-1:0]      cell_index,
   input  ils_pkg::cell_cmd_type          cmd,
   input  logic [ils_pkg::WORD_WIDTH-1:0] load_word,
   input  logic [ils_pkg::WORD_WIDTH-1:0] lower_word,
   input  logic [ils_pkg::WORD_WIDTH-1:0] upper_word,
   output logic [ils_pkg::WORD_WIDTH-1:0] word
);
   import ils_pkg::*;

   logic [WORD_WIDTH-1:0] word_ff;
   logic [WORD_WIDTH-1:0] word_in;
   logic [CNT_W-1:0]      me;
   logic [CNT_W-1:0]      me_next;

   assign me      = CNT_W'(cell_index);
   assign me_next = CNT_W'(me + 1'b1);

   always_comb begin
      word_in = word_ff;
      unique case (cmd.op)
         CELL_LOAD_AT: begin
            if (me == cmd.pos) word_in = load_word;
         end
         CELL_INSERT: begin
            // entries from pos up to the old end move up one place
            if (me == cmd.pos) word_in = load_word;
            else if (me > cmd.pos && me <= cmd.lim) word_in = lower_word;
         end
         CELL_REMOVE: begin
            if (me >= cmd.pos && me_next < cmd.lim) word_in = upper_word;
         end
         CELL_FILL: begin
            if (me >= cmd.pos && me < cmd.lim) word_in = load_word;
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

// File: design/ils_ctrl.sv
// ----------------------------------------------------------------------------
// ils_ctrl: request decoder
// Checks a request against the current length and turns it into a command
// for the cell row, a read select, a status and the next length.
// ----------------------------------------------------------------------------
module ils_ctrl (
   input  logic [ils_pkg::ACTION_W-1:0]  action,
   input  logic [ils_pkg::REQ_IDX_W-1:0] index,
   input  logic [ils_pkg::REQ_IDX_W-1:0] new_length,
   input  logic [ils_pkg::CNT_W-1:0]     count,
   output ils_pkg::cell_cmd_type         cmd,
   output ils_pkg::ctrl_res_type         res
);
   import ils_pkg::*;

   logic [CMP_W-1:0] cnt_x;
   logic [CMP_W-1:0] idx_x;
   logic [CMP_W-1:0] nlen_x;
   logic [CMP_W-1:0] depth_x;
   logic [CNT_W-1:0] cnt_up;
   logic [CNT_W-1:0] cnt_dn;

   assign cnt_x   = CMP_W'(count);
   assign idx_x   = CMP_W'(index);
   assign nlen_x  = CMP_W'(new_length);
   assign depth_x = CMP_W'(DEPTH);
   assign cnt_up  = CNT_W'(count + 1'b1);
   assign cnt_dn  = CNT_W'(count - 1'b1);

   always_comb begin
      cmd.op         = CELL_HOLD;
      cmd.pos        = count;
      cmd.lim        = count;
      res.rd_en      = 1'b0;
      res.rd_sel     = IDX_W'(idx_x);
      res.status     = ST_OK;
      res.next_count = count;
      unique case (action)
         ACT_PUSH: begin
            if (cnt_x >= depth_x) begin
               res.status = ST_FULL;
            end else begin
               cmd.op         = CELL_LOAD_AT;
               res.next_count = cnt_up;
            end
         end
         ACT_POP: begin
            if (count == '0) begin
               res.status = ST_BAD;
            end else begin
               res.rd_en      = 1'b1;
               res.rd_sel     = IDX_W'(cnt_dn);
               res.next_count = cnt_dn;
            end
         end
         ACT_INSERT: begin
            // index is checked before fullness
            if (idx_x > cnt_x) begin
               res.status = ST_BAD;
            end else if (cnt_x >= depth_x) begin
               res.status = ST_FULL;
            end else begin
               cmd.op         = CELL_INSERT;
               cmd.pos        = CNT_W'(idx_x);
               res.next_count = cnt_up;
            end
         end
         ACT_REMOVE: begin
            if (idx_x >= cnt_x) begin
               res.status = ST_BAD;
            end else begin
               cmd.op         = CELL_REMOVE;
               cmd.pos        = CNT_W'(idx_x);
               res.next_count = cnt_dn;
            end
         end
         ACT_READ: begin
            if (idx_x >= cnt_x) res.status = ST_BAD;
            else res.rd_en = 1'b1;
         end
         ACT_OVERWRITE: begin
            if (idx_x >= cnt_x) begin
               res.status = ST_BAD;
            end else begin
               cmd.op  = CELL_LOAD_AT;
               cmd.pos = CNT_W'(idx_x);
            end
         end
         ACT_RESIZE: begin
            if (nlen_x > depth_x) begin
               res.status = ST_FULL;
            end else begin
               // only the grown tail is filled; shrinking just drops the length
               cmd.op         = CELL_FILL;
               cmd.lim        = CNT_W'(nlen_x);
               res.next_count = CNT_W'(nlen_x);
            end
         end
         default: begin
            res.status = ST_OK;
         end
      endcase
   end

endmodule

// File: design/indexed_list_store_core.sv
// ----------------------------------------------------------------------------
// indexed_list_store_core: ordered list of words in a row of shifting cells
// Push, pop, insert, remove, read, overwrite and resize on a fixed store.
// ----------------------------------------------------------------------------
//  channel    ports                                   handshake
//  request    req_action req_index req_value          start high, busy low
//             req_new_length
//  response   rsp_read_data rsp_length rsp_status     rsp_valid for one cycle
//
//  all cells shift in parallel, so insert and remove finish as fast as a
//  read; the response shows the cycle after accept.
//  busy stays low and a request may be given in every cycle.
//  reset clears the length and the response strobe; cell contents are kept.
//  the receiver cannot stall; a response is gone after its one cycle.
// ----------------------------------------------------------------------------
module indexed_list_store_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [ils_pkg::ACTION_W-1:0]   req_action,
   input  logic [ils_pkg::REQ_IDX_W-1:0]  req_index,
   input  logic [ils_pkg::DATA_W-1:0]     req_value,
   input  logic [ils_pkg::REQ_IDX_W-1:0]  req_new_length,
   output logic                           rsp_valid,
   output logic [ils_pkg::DATA_W-1:0]     rsp_read_data,
   output logic [ils_pkg::LEN_W-1:0]      rsp_length,
   output logic [ils_pkg::STATUS_W-1:0]   rsp_status
);
   import ils_pkg::*;

   logic                               accept;
   logic [CNT_W-1:0]                   count_ff;
   logic [CNT_W-1:0]                   count_in;
   logic                               rsp_valid_ff;
   logic [DATA_W-1:0]                  rsp_data_ff;
   logic [DATA_W-1:0]                  rsp_data_in;
   logic [CNT_W-1:0]                   rsp_len_ff;
   logic [STATUS_W-1:0]                rsp_status_ff;
   cell_cmd_type                       dec_cmd;
   cell_cmd_type                       cell_cmd;
   ctrl_res_type                       dec_res;
   logic [WORD_WIDTH-1:0]              load_word;
   logic [DEPTH-1:0][WORD_WIDTH-1:0]   words;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   ils_ctrl u_ctrl (
      .action     (req_action),
      .index      (req_index),
      .new_length (req_new_length),
      .count      (count_ff),
      .cmd        (dec_cmd),
      .res        (dec_res)
   );

   always_comb begin
      cell_cmd = dec_cmd;
      if (!accept || reset) cell_cmd.op = CELL_HOLD;
   end

   assign load_word = data_to_word(req_value);

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [WORD_WIDTH-1:0] lower_w;
      logic [WORD_WIDTH-1:0] upper_w;
      if (g == 0) begin : g_first
         assign lower_w = '0;
      end else begin : g_mid_lo
         assign lower_w = words[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign upper_w = '0;
      end else begin : g_mid_hi
         assign upper_w = words[g+1];
      end
      ils_cell u_cell (
         .clock      (clock),
         .cell_index (IDX_W'(g)),
         .cmd        (cell_cmd),
         .load_word  (load_word),
         .lower_word (lower_w),
         .upper_word (upper_w),
         .word       (words[g])
      );
   end

   always_comb begin
      count_in    = accept ? dec_res.next_count : count_ff;
      rsp_data_in = dec_res.rd_en ? word_to_data(words[dec_res.rd_sel]) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_len_ff    <= dec_res.next_count;
         rsp_status_ff <= dec_res.status;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_length    = LEN_W'(rsp_len_ff);
   assign rsp_status    = rsp_status_ff;

endmodule

// File: design/ils_checker.sv
// ----------------------------------------------------------------------------
// ils_checker: port-level checks for the indexed list store
// Watches requests and responses on the top level ports.
// ----------------------------------------------------------------------------
module ils_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_valid,
   input logic [ils_pkg::DATA_W-1:0]     rsp_read_data,
   input logic [ils_pkg::LEN_W-1:0]      rsp_length,
   input logic [ils_pkg::STATUS_W-1:0]   rsp_status
);
   import ils_pkg::*;

   // each accepted request gives exactly one response, in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("request without response");

   a_no_stray_rsp: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_valid)
      else $error("response without request");

   // failed requests never return data
   a_fail_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> rsp_read_data == '0)
      else $error("data on failed request");

   // a failed request leaves the length as it was (checked only on back-to-back responses)
   a_fail_keeps_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(rsp_valid) && rsp_status != ST_OK)
         |-> rsp_length == $past(rsp_length))
      else $error("failed request changed length");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_FULL || rsp_status == ST_BAD))
      else $error("bad status code");

endmodule

bind indexed_list_store_core ils_checker u_ils_checker (.*);

// File: verif/ils_list_checker.sv
// ----------------------------------------------------------------------------
// ils_list_checker: response checker for the indexed list store
// Watches the request and response channels, keeps a shadow copy of the list,
// predicts each response and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module ils_list_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  logic [ils_pkg::ACTION_W-1:0]   req_action,
   input  logic [ils_pkg::REQ_IDX_W-1:0]  req_index,
   input  logic [ils_pkg::DATA_W-1:0]     req_value,
   input  logic [ils_pkg::REQ_IDX_W-1:0]  req_new_length,
   input  logic                           rsp_valid,
   input  logic [ils_pkg::DATA_W-1:0]     rsp_read_data,
   input  logic [ils_pkg::LEN_W-1:0]      rsp_length,
   input  logic [ils_pkg::STATUS_W-1:0]   rsp_status,
   input  logic                           run_done,
   output int                             fail_count,
   output int                             pending,
   output int                             n_checked,
   output int                             n_full,
   output int                             n_bad
);
   timeunit 1ns;
   timeprecision 1ps;
   import ils_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0]   data;
      logic [LEN_W-1:0]    length;
      logic [STATUS_W-1:0] status;
   } list_outcome_type;

   logic [WORD_WIDTH-1:0] shadow_words [DEPTH];
   int                    shadow_len;
   list_outcome_type      outcome_q [$];
   bit                    leftovers_swept;

   task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
                                input logic [DATA_W-1:0] want);
      $display("MISMATCH %s: got 0x%08h want 0x%08h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   // updates the shadow list and returns the response the request should give
   function automatic list_outcome_type apply_list_request(
      input logic [ACTION_W-1:0]  act,
      input logic [REQ_IDX_W-1:0] idx,
      input logic [DATA_W-1:0]    val,
      input logic [REQ_IDX_W-1:0] nlen);
      list_outcome_type      res;
      logic [WORD_WIDTH-1:0] word;
      int                    ix;
      int                    nl;
      int                    i;
      res.data   = '0;
      res.status = ST_OK;
      word       = val[WORD_WIDTH-1:0];
      ix         = int'(idx);
      nl         = int'(nlen);
      case (act)
         ACT_PUSH: begin
            if (shadow_len >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               shadow_words[shadow_len] = word;
               shadow_len++;
            end
         end
         ACT_POP: begin
            if (shadow_len == 0) begin
               res.status = ST_BAD;
            end else begin
               shadow_len--;
               res.data = DATA_W'(shadow_words[shadow_len]);
            end
         end
         ACT_INSERT: begin
            // index is checked before fullness
            if (ix > shadow_len) begin
               res.status = ST_BAD;
            end else if (shadow_len >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               for (i = shadow_len; i > ix; i--) shadow_words[i] = shadow_words[i-1];
               shadow_words[ix] = word;
               shadow_len++;
            end
         end
         ACT_REMOVE: begin
            if (ix >= shadow_len) begin
               res.status = ST_BAD;
            end else begin
               for (i = ix; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
               shadow_len--;
            end
         end
         ACT_READ: begin
            if (ix >= shadow_len) res.status = ST_BAD;
            else res.data = DATA_W'(shadow_words[ix]);
         end
         ACT_OVERWRITE: begin
            if (ix >= shadow_len) res.status = ST_BAD;
            else shadow_words[ix] = word;
         end
         ACT_RESIZE: begin
            if (nl > DEPTH) begin
               res.status = ST_FULL;
            end else begin
               for (i = shadow_len; i < nl; i++) shadow_words[i] = word;
               shadow_len = nl;
            end
         end
         default: ;
      endcase
      res.length = LEN_W'(shadow_len);
      return res;
   endfunction

   always @(posedge clock) begin : watch
      list_outcome_type want;
      if (reset) begin
         outcome_q.delete();
         shadow_len = 0;
         pending <= 0;
      end else begin
         // the response of an earlier request is retired before a new one is queued
         if (rsp_valid) begin
            if (outcome_q.size() == 0) begin
               flag_mismatch("response with no request waiting", rsp_read_data, '0);
            end else begin
               want = outcome_q.pop_front();
               n_checked++;
               if (rsp_read_data !== want.data)
                  flag_mismatch("read_data", rsp_read_data, want.data);
               if (rsp_length !== want.length)
                  flag_mismatch("length", DATA_W'(rsp_length), DATA_W'(want.length));
               if (rsp_status !== want.status)
                  flag_mismatch("status", DATA_W'(rsp_status), DATA_W'(want.status));
            end
         end
         if (start && !busy) begin
            want = apply_list_request(req_action, req_index, req_value, req_new_length);
            if (want.status == ST_FULL) n_full++;
            if (want.status == ST_BAD) n_bad++;
            outcome_q.push_back(want);
         end
         pending <= outcome_q.size();
         if (run_done && !leftovers_swept) begin
            leftovers_swept = 1'b1;
            if (outcome_q.size() != 0)
               flag_mismatch("requests left without response", outcome_q.size(), '0);
         end
      end
   end

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for indexed_list_store_core
// Drives directed corner requests, then random request streams that swing the
// list between empty and full, with random start gaps; the checker scores.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ils_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;
   localparam int RANDOM_ITEMS = 1525;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [ACTION_W-1:0]   req_action = ACT_PUSH;
   logic [REQ_IDX_W-1:0]  req_index = '0;
   logic [DATA_W-1:0]     req_value = '0;
   logic [REQ_IDX_W-1:0]  req_new_length = '0;
   logic                  rsp_valid;
   logic [DATA_W-1:0]     rsp_read_data;
   logic [LEN_W-1:0]      rsp_length;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  run_done = 1'b0;

   int fail_count, pending, n_checked, n_full, n_bad;
   int requests_sent;
   int directed_sent;
   int list_len_est;
   bit no_gaps;

   indexed_list_store_core dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_index      (req_index),
      .req_value      (req_value),
      .req_new_length (req_new_length),
      .rsp_valid      (rsp_valid),
      .rsp_read_data  (rsp_read_data),
      .rsp_length     (rsp_length),
      .rsp_status     (rsp_status)
   );

   ils_list_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_index      (req_index),
      .req_value      (req_value),
      .req_new_length (req_new_length),
      .rsp_valid      (rsp_valid),
      .rsp_read_data  (rsp_read_data),
      .rsp_length     (rsp_length),
      .rsp_status     (rsp_status),
      .run_done       (run_done),
      .fail_count     (fail_count),
      .pending        (pending),
      .n_checked      (n_checked),
      .n_full         (n_full),
      .n_bad          (n_bad)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic logic [DATA_W-1:0] rand_word();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return DATA_W'($urandom);
   endfunction

   // optional idle gap, then hold the request until it is taken
   task automatic issue(input logic [ACTION_W-1:0]  act,
                        input logic [REQ_IDX_W-1:0] idx,
                        input logic [DATA_W-1:0]    val,
                        input logic [REQ_IDX_W-1:0] nlen);
      int r;
      int gap;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 50) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else if (r < 96) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 60);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_action     <= act;
      req_index      <= idx;
      req_value      <= val;
      req_new_length <= nlen;
      @(posedge clock);
      while (busy) @(posedge clock);
      requests_sent++;
      // rough length track, only used to aim indexes at the live part of the list
      case (act)
         ACT_PUSH:   if (list_len_est < DEPTH) list_len_est++;
         ACT_POP:    if (list_len_est > 0) list_len_est--;
         ACT_INSERT: if (idx <= list_len_est && list_len_est < DEPTH) list_len_est++;
         ACT_REMOVE: if (idx < list_len_est) list_len_est--;
         ACT_RESIZE: if (nlen <= DEPTH) list_len_est = nlen;
         default: ;
      endcase
   endtask

   initial begin : stimulus
      logic [ACTION_W-1:0]  act_codes [7];
      int                   cuts [7];
      logic [ACTION_W-1:0]  act;
      logic [REQ_IDX_W-1:0] idx;
      logic [REQ_IDX_W-1:0] nlen;
      int                   valid_hi;
      int                   r;
      int                   k;
      int                   waited;

      act_codes = '{ACT_PUSH, ACT_POP, ACT_INSERT, ACT_REMOVE, ACT_READ,
                    ACT_OVERWRITE, ACT_RESIZE};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // corner cases on an empty list, then on a short list
      issue(ACT_POP, 0, 32'h1234_5678, 0);
      issue(ACT_READ, 0, 0, 0);
      issue(ACT_REMOVE, 0, 0, 0);
      issue(ACT_OVERWRITE, 0, 32'hFFFF_FFFF, 0);
      issue(ACT_INSERT, 1, 32'h0BAD_0BAD, 0);
      issue(ACT_INSERT, 0, 32'hFFFF_FFFF, 0);
      issue(ACT_PUSH, 0, 32'h0000_0000, 0);
      issue(ACT_PUSH, 0, 32'hA5A5_A5A5, 0);
      issue(ACT_INSERT, 1, 32'h8000_0001, 0);
      issue(ACT_READ, 0, 0, 0);
      issue(ACT_OVERWRITE, 1, 32'h5555_AAAA, 0);
      issue(ACT_REMOVE, 0, 0, 0);
      // grow to full, then the full-list cases, then shrink back
      issue(ACT_RESIZE, 31, 32'h5A5A_5A5A, 16);
      issue(ACT_PUSH, 0, 32'hDEAD_0001, 0);
      issue(ACT_INSERT, 3, 32'hDEAD_0002, 0);
      issue(ACT_INSERT, 20, 32'hDEAD_0003, 0);
      issue(ACT_READ, 15, 0, 0);
      issue(ACT_READ, 16, 0, 0);
      issue(ACT_READ, 31, 0, 0);
      issue(ACT_RESIZE, 0, 32'h1111_1111, 17);
      issue(ACT_RESIZE, 0, 32'h2222_2222, 31);
      issue(ACT_RESIZE, 0, 32'h3333_3333, 16);
      issue(ACT_UNUSED, 31, 32'hFFFF_FFFF, 31);
      issue(ACT_RESIZE, 0, 0, 0);
      issue(ACT_RESIZE, 0, 32'hC0DE_C0DE, 3);
      issue(ACT_REMOVE, 2, 0, 0);
      issue(ACT_POP, 0, 0, 0);
      directed_sent = requests_sent;

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         no_gaps = (n % 300) >= 240;
         // alternate phases that favor push and pop, then insert and remove
         if ((n / 120) % 2 == 0) cuts = '{30, 50, 58, 66, 80, 90, 98};
         else cuts = '{10, 20, 40, 60, 75, 88, 98};
         r = $urandom_range(0, 99);
         act = ACT_UNUSED;
         for (k = 6; k >= 0; k--) if (r < cuts[k]) act = act_codes[k];

         valid_hi = (act == ACT_INSERT) ? list_len_est : list_len_est - 1;
         if (valid_hi < 0) valid_hi = 0;
         r = $urandom_range(0, 99);
         if (r < 82) idx = REQ_IDX_W'($urandom_range(0, valid_hi));
         else if (r < 94) idx = REQ_IDX_W'($urandom_range(0, DEPTH));
         else idx = REQ_IDX_W'($urandom_range(0, 31));

         r = $urandom_range(0, 99);
         if (act != ACT_RESIZE) nlen = REQ_IDX_W'($urandom_range(0, 31));
         else if (r < 70) nlen = REQ_IDX_W'($urandom_range(0, DEPTH));
         else if (r < 88) nlen = REQ_IDX_W'($urandom_range(
                                   (list_len_est > 2) ? list_len_est - 2 : 0,
                                   (list_len_est < DEPTH - 2) ? list_len_est + 2 : DEPTH));
         else nlen = REQ_IDX_W'($urandom_range(DEPTH + 1, 31));

         issue(act, idx, rand_word(), nlen);
      end
      start <= 1'b0;

      waited = 0;
      while (pending != 0 && waited < 1000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
      run_done <= 1'b1;
      repeat (2) @(posedge clock);

      $display("ran %0d requests (%0d directed), %0d responses checked",
               requests_sent, directed_sent, n_checked);
      $display("saw %0d full or too-large and %0d empty or bad-index outcomes",
               n_full, n_bad);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
